/* rtl/wshc_pkg.sv */
// ============================================================================
// wshc_pkg: shared types and constants
// Op codes, queue entry type, MD5 constant tables and helpers.
// ============================================================================
package wshc_pkg;

  localparam logic [1:0] OpKey1      = 2'd0;
  localparam logic [1:0] OpKey2      = 2'd1;
  localparam logic [1:0] OpChallenge = 2'd2;
  localparam logic [1:0] OpUnused    = 2'd3;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = 1;

  // Job handed from the front to the back.
  typedef struct packed {
    logic [31:0] first_value;
    logic [31:0] first_spaces;
    logic [31:0] second_value;
    logic [31:0] second_spaces;
    logic [63:0] challenge;
  } job_t;

  typedef struct packed {
    logic [63:0] response_part;
    logic        is_last;
    logic        ok;
  } result_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_r(input logic [3:0] idx);
    logic [4:0] r;
    unique case (idx)
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage

/* rtl/wshc_if.sv */
// ============================================================================
// wshc_in_if / wshc_out_if: valid-ready channels
// Input item channel and result channel of the challenge responder.
// ============================================================================
interface wshc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  char_byte;
  logic [63:0] challenge_word;
  modport source (output valid, op, char_byte, challenge_word, input ready);
  modport sink   (input valid, op, char_byte, challenge_word, output ready);
endinterface

interface wshc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] response_part;
  logic        is_last;
  logic        ok;
  modport source (output valid, response_part, is_last, ok, input ready);
  modport sink   (input valid, response_part, is_last, ok, output ready);
endinterface

/* rtl/websocket_hixie76_challenge.sv */
// ============================================================================
// websocket_hixie76_challenge: handshake challenge responder
// Folds two key strings and answers the challenge with an MD5 digest.
// ============================================================================
// Usage: items arrive on in_if (valid/ready). Op key1/key2 transactions
// carry one key character each and are taken one per cycle while in_if
// ready is high; they give no result. A challenge transaction carries the
// eight challenge bytes and is queued for the back end, then the key state
// clears at once so that the next keys may stream in while the digest is
// being worked out. The back end takes the job, runs the two restoring
// dividers and then the MD5 rounds, one round a cycle, and offers two result
// transactions on out_if (digest bytes 0-7, then 8-15 with is_last). If a key
// held no space, one result with ok low follows in the cycle after the job
// is taken. The two-entry queue lets key characters keep flowing while the
// engine runs a challenge. When the receiver stalls, the result holds and
// once the queue fills, in_if ready drops.
// Reset clears the key state, the queue and the engine; no result is pending.
// ============================================================================
module websocket_hixie76_challenge (
  input  logic       clk_i,
  input  logic       rst_ni,
  wshc_in_if.sink    in_if,
  wshc_out_if.source out_if
);
  import wshc_pkg::*;

  logic push, full, qvalid, pop;
  job_t job_in, job_out;

  wshc_front u_front (.clk_i, .rst_ni, .in_if, .push_o(push), .job_o(job_in),
                      .full_i(full));
  wshc_queue u_queue (.clk_i, .rst_ni, .push_i(push), .job_i(job_in), .full_o(full),
                      .valid_o(qvalid), .job_o(job_out), .pop_i(pop));
  wshc_back  u_back  (.clk_i, .rst_ni, .valid_i(qvalid), .job_i(job_out), .pop_o(pop),
                      .out_if);
endmodule

/* rtl/wshc_front.sv */
// ============================================================================
// wshc_front: key character folding
// Accepts items, folds key digits and counts spaces, and pushes a job for
// each challenge item into the queue.
// ============================================================================
module wshc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  wshc_in_if.sink           in_if,
  output logic              push_o,
  output wshc_pkg::job_t    job_o,
  input  logic              full_i
);
  import wshc_pkg::*;

  logic [31:0] v1_q, v1_d, s1_q, s1_d, v2_q, v2_d, s2_q, s2_d;
  logic        acc;
  logic        is_digit, is_space;
  logic [31:0] sel_v, sel_s, new_v, new_s;

  assign in_if.ready = !full_i;
  assign acc = in_if.valid && in_if.ready;
  assign is_digit = (in_if.char_byte >= CharZero) && (in_if.char_byte <= CharNine);
  assign is_space = (in_if.char_byte == CharSpace);

  assign sel_v = (in_if.op == OpKey1) ? v1_q : v2_q;
  assign sel_s = (in_if.op == OpKey1) ? s1_q : s2_q;

  always_comb begin
    new_v = sel_v;
    new_s = sel_s;
    if (is_digit) begin
      new_v = (sel_v << 3) + (sel_v << 1) + {24'd0, in_if.char_byte - CharZero};
    end else if (is_space && (sel_s != 32'hFFFF_FFFF)) begin
      new_s = sel_s + 32'd1;
    end
  end

  always_comb begin
    v1_d = v1_q; s1_d = s1_q; v2_d = v2_q; s2_d = s2_q;
    if (acc) begin
      unique case (in_if.op)
        OpKey1: begin v1_d = new_v; s1_d = new_s; end
        OpKey2: begin v2_d = new_v; s2_d = new_s; end
        OpChallenge: begin v1_d = '0; s1_d = '0; v2_d = '0; s2_d = '0; end
        default: ;
      endcase
    end
  end

  assign push_o = acc && (in_if.op == OpChallenge);
  assign job_o  = '{first_value: v1_q, first_spaces: s1_q, second_value: v2_q,
                    second_spaces: s2_q, challenge: in_if.challenge_word};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= '0; s1_q <= '0; v2_q <= '0; s2_q <= '0;
    end else begin
      v1_q <= v1_d; s1_q <= s1_d; v2_q <= v2_d; s2_q <= s2_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (v1_q == '0 && s2_q == '0))
    else $error("key state not cleared after challenge");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_if.op == OpKey1) |=> $stable(v2_q) && $stable(s2_q))
    else $error("key1 character disturbed key2 state");
endmodule

/* rtl/wshc_queue.sv */
// ============================================================================
// wshc_queue: job queue
// Short first-in first-out store between the front and the back.
// ============================================================================
module wshc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wshc_pkg::job_t    job_i,
  output logic              full_o,
  output logic              valid_o,
  output wshc_pkg::job_t    job_o,
  input  logic              pop_i
);
  import wshc_pkg::*;

  job_t              mem_q [QueueDepth];
  logic [QueueAw-1:0] wp_q, rp_q;
  logic [QueueAw:0]   cnt_q;

  assign full_o  = (cnt_q == (QueueAw+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QueueAw+1)'(push_i) - (QueueAw+1)'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueueAw+1)'(QueueDepth)) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> valid_o) else $error("push lost");
endmodule

/* rtl/wshc_back.sv */
// ============================================================================
// wshc_back: divide and MD5 engine
// Takes a job, runs two restoring dividers in 32 steps, then 64 MD5 rounds,
// and emits two digest results, or one ok-low result if a key had no space.
// ============================================================================
module wshc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  wshc_pkg::job_t    job_i,
  output logic              pop_o,
  wshc_out_if.source        out_if
);
  import wshc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StMd5  = 3'd2;
  localparam logic [2:0] StOut0 = 3'd3;
  localparam logic [2:0] StOut1 = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] n1_q, n1_d, n2_q, n2_d, r1_q, r1_d, r2_q, r2_d, d1_q, d1_d, d2_q, d2_d;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d, dd_q, dd_d;
  logic [31:0] m0_q, m0_d, m1_q, m1_d, m2_q, m2_d, m3_q, m3_d;
  logic [63:0] out_q, out_d;
  logic        last_q, last_d, ok_q, ok_d;

  logic [32:0] t1, t2;
  logic [31:0] f, mg, sum, rot;
  logic [3:0]  g;
  logic [4:0]  sh;
  logic [31:0] h0, h1, h2, h3;
  logic [1:0]  rnd;
  logic [63:0] shown;

  assign rnd = cnt_q[5:4];
  assign t1 = {r1_q, n1_q[31]} - {1'b0, d1_q};
  assign t2 = {r2_q, n2_q[31]} - {1'b0, d2_q};

  always_comb begin
    unique case (rnd)
      2'd0: begin f = (b_q & c_q) | (~b_q & dd_q); g = cnt_q[3:0]; end
      2'd1: begin f = (dd_q & b_q) | (~dd_q & c_q); g = 4'(cnt_q * 6'd5 + 6'd1); end
      2'd2: begin f = b_q ^ c_q ^ dd_q; g = 4'(cnt_q * 6'd3 + 6'd5); end
      default: begin f = c_q ^ (b_q | ~dd_q); g = 4'(cnt_q * 6'd7); end
    endcase
  end

  always_comb begin
    unique case (g)
      4'd0: mg = m0_q;
      4'd1: mg = m1_q;
      4'd2: mg = m2_q;
      4'd3: mg = m3_q;
      4'd4: mg = 32'h80;
      4'd14: mg = 32'd128;
      default: mg = '0;
    endcase
  end

  assign sh  = md5_r({rnd, cnt_q[1:0]});
  assign sum = a_q + f + md5_k(cnt_q) + mg;
  assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

  assign h0 = 32'h67452301 + a_q;
  assign h1 = 32'hefcdab89 + b_q;
  assign h2 = 32'h98badcfe + c_q;
  assign h3 = 32'h10325476 + dd_q;

  assign pop_o = (st_q == StIdle) && valid_i;
  assign out_if.valid = (st_q == StOut0) || (st_q == StOut1);
  assign out_if.response_part = shown;
  assign out_if.is_last = last_q;
  assign out_if.ok = ok_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q;
    n1_d = n1_q; n2_d = n2_q; r1_d = r1_q; r2_d = r2_q; d1_d = d1_q; d2_d = d2_q;
    a_d = a_q; b_d = b_q; c_d = c_q; dd_d = dd_q;
    m0_d = m0_q; m1_d = m1_q; m2_d = m2_q; m3_d = m3_q;
    out_d = out_q; last_d = last_q; ok_d = ok_q;
    unique case (st_q)
      StIdle: if (valid_i) begin
        if (job_i.first_spaces == '0 || job_i.second_spaces == '0) begin
          out_d = '0; last_d = 1'b1; ok_d = 1'b0; st_d = StOut1;
        end else begin
          n1_d = job_i.first_value; n2_d = job_i.second_value;
          d1_d = job_i.first_spaces; d2_d = job_i.second_spaces;
          r1_d = '0; r2_d = '0;
          m2_d = swap32(job_i.challenge[63:32]);
          m3_d = swap32(job_i.challenge[31:0]);
          cnt_d = '0; st_d = StDiv;
        end
      end
      StDiv: begin
        // One quotient bit per divider per cycle, shifted in at the bottom.
        r1_d = t1[32] ? {r1_q[30:0], n1_q[31]} : t1[31:0];
        r2_d = t2[32] ? {r2_q[30:0], n2_q[31]} : t2[31:0];
        n1_d = {n1_q[30:0], ~t1[32]};
        n2_d = {n2_q[30:0], ~t2[32]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          m0_d = swap32({n1_q[30:0], ~t1[32]});
          m1_d = swap32({n2_q[30:0], ~t2[32]});
          a_d = 32'h67452301; b_d = 32'hefcdab89;
          c_d = 32'h98badcfe; dd_d = 32'h10325476;
          cnt_d = '0; st_d = StMd5;
        end
      end
      StMd5: begin
        a_d = dd_q; dd_d = c_q; c_d = b_q; b_d = b_q + rot;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          last_d = 1'b0; ok_d = 1'b1; st_d = StOut0;
        end
      end
      StOut0: begin
        out_d = {swap32(h0), swap32(h1)}; last_d = 1'b0; ok_d = 1'b1;
        if (out_if.valid && out_if.ready) begin
          out_d = {swap32(h2), swap32(h3)}; last_d = 1'b1; st_d = StOut1;
        end
      end
      StOut1: if (out_if.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // The first half is formed combinationally from the final chaining words.
  assign shown = (st_q == StOut0) ? {swap32(h0), swap32(h1)} : out_q;

  always_ff @(posedge clk_i) begin
    n1_q <= n1_d; n2_q <= n2_d; r1_q <= r1_d; r2_q <= r2_d; d1_q <= d1_d; d2_q <= d2_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; dd_q <= dd_d;
    m0_q <= m0_d; m1_q <= m1_d; m2_q <= m2_d; m3_q <= m3_d;
    out_q <= out_d; last_q <= last_d; ok_q <= ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut0) |-> (shown == {swap32(h0), swap32(h1)}))
    else $error("first digest half mismatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut1) |-> out_if.is_last)
    else $error("last flag missing");
endmodule

/* tb/sv/testbench.sv */
// ============================================================================
// testbench: challenge responder check
// Streams key characters and challenges with random gaps and receiver stalls,
// predicts each digest half and compares every result transaction in order.
// ============================================================================
module testbench;
  import wshc_pkg::*;

  logic clk_i;
  logic rst_ni;

  wshc_in_if  in_if ();
  wshc_out_if out_if ();

  websocket_hixie76_challenge uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Predictor state for the key fold.
  logic [31:0] key_val [2];
  logic [31:0] key_spc [2];

  result_t digest_q [$];
  int      mismatches;
  int      items_sent;
  bit      hold_off;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int c);
    return (x << c) | (x >> (32 - c));
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [127:0] md5_of16(input logic [31:0] q1, input logic [31:0] q2,
                                            input logic [63:0] cw);
    logic [31:0] kt [64];
    int          sh [16];
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int          g;
    kt = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
           32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
           32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
           32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
           32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
           32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
           32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
           32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
           32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
           32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
           32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
           32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
           32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    sh = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    foreach (m[j]) m[j] = '0;
    m[0] = bswap(q1);
    m[1] = bswap(q2);
    m[2] = bswap(cw[63:32]);
    m[3] = bswap(cw[31:0]);
    m[4] = 32'h80;
    m[14] = 32'd128;
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      t = d;
      d = c;
      c = b;
      b = b + rol(a + f + kt[i] + m[g], sh[(i / 16) * 4 + i % 4]);
      a = t;
    end
    return {bswap(32'h67452301 + a), bswap(32'hefcdab89 + b),
            bswap(32'h98badcfe + c), bswap(32'h10325476 + d)};
  endfunction

  function automatic void clear_keys();
    for (int k = 0; k < 2; k++) begin
      key_val[k] = '0;
      key_spc[k] = '0;
    end
  endfunction

  // Applies one accepted transaction to the predictor.
  function automatic void predict_item(input logic [1:0] op, input logic [7:0] ch,
                                       input logic [63:0] cw);
    logic [127:0] dg;
    int           k;
    if (op == OpKey1 || op == OpKey2) begin
      k = (op == OpKey1) ? 0 : 1;
      if (ch >= CharZero && ch <= CharNine)
        key_val[k] = key_val[k] * 32'd10 + 32'(ch - CharZero);
      else if (ch == CharSpace && key_spc[k] != 32'hFFFF_FFFF)
        key_spc[k] = key_spc[k] + 32'd1;
    end else if (op == OpChallenge) begin
      if (key_spc[0] == 0 || key_spc[1] == 0) begin
        digest_q.push_back('{response_part: 64'd0, is_last: 1'b1, ok: 1'b0});
      end else begin
        dg = md5_of16(key_val[0] / key_spc[0], key_val[1] / key_spc[1], cw);
        digest_q.push_back('{response_part: dg[127:64], is_last: 1'b0, ok: 1'b1});
        digest_q.push_back('{response_part: dg[63:0], is_last: 1'b1, ok: 1'b1});
      end
      clear_keys();
    end
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic [63:0] cw);
    in_if.valid          <= 1'b1;
    in_if.op             <= op;
    in_if.char_byte      <= ch;
    in_if.challenge_word <= cw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_item(op, ch, cw);
    items_sent++;
    // Random gap between bursts; valid stays high otherwise.
    if ($urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic idle_sender();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_key(input logic [1:0] op, input string s);
    for (int i = 0; i < s.len(); i++) send_item(op, s[i], '0);
  endtask

  task automatic test_directed();
    send_key(OpKey1, "18x 6]0 4 ");
    send_key(OpKey2, "1_ 3 9 4 8 2 0");
    send_item(OpChallenge, 8'h00, 64'h5461_7f42_3a21_0044);
    // A key without spaces gives a single failure result.
    send_key(OpKey1, "1234");
    send_item(OpChallenge, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    // Second key without spaces, with ignored bytes and the spare op code.
    send_item(OpKey1, CharSpace, '0);
    send_item(OpKey2, 8'h00, '0);
    send_item(OpKey2, 8'hFF, '0);
    send_item(OpUnused, 8'h20, 64'h1);
    send_item(OpChallenge, 8'h00, 64'h0);
    // Both keys empty, then a wrapping key1 and a zero key2, one space each.
    send_item(OpChallenge, 8'h00, 64'h8000_0000_0000_0001);
    send_key(OpKey1, "9999999999 ");
    send_key(OpKey2, " 0");
    send_item(OpChallenge, 8'h00, 64'h0123_4567_89AB_CDEF);
    wait_drained();
  endtask

  task automatic send_random_key(input logic [1:0] op);
    int n;
    n = $urandom_range(1, 14);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_item(op, 8'(CharZero + $urandom_range(0, 9)), '0);
        6, 7: send_item(op, CharSpace, '0);
        default: send_item(op, 8'($urandom), {$urandom, $urandom});
      endcase
    end
  endtask

  task automatic test_random_handshakes(input int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OpUnused, 8'($urandom), {$urandom, $urandom});
      end
      if ($urandom_range(0, 7) != 0) send_random_key(OpKey1);
      if ($urandom_range(0, 7) != 0) send_random_key(OpKey2);
      send_item(OpChallenge, 8'($urandom), {$urandom, $urandom});
    end
    wait_drained();
  endtask

  // Receiver held off while challenges pile up behind the queue.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_key(OpKey1, "5 1");
      send_key(OpKey2, " 77 ");
      send_item(OpChallenge, 8'h00, {$urandom, $urandom});
    end
    wait_drained();
  endtask

  task automatic test_saturation();
    // Push a space count well past the usual so the divider sees large counts.
    for (int i = 0; i < 300; i++) send_item(OpKey1, CharSpace, '0);
    send_key(OpKey1, "4294967295");
    send_key(OpKey2, "7 ");
    send_item(OpChallenge, 8'h00, 64'hA5A5_5A5A_0F0F_F0F0);
    wait_drained();
  endtask

  // Receiver stall pattern, plus the long hold-off when requested.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= $urandom_range(0, 1);
        default: out_if.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_if.response_part);
      end else begin
        exp_r = digest_q.pop_front();
        if (out_if.response_part !== exp_r.response_part || out_if.is_last !== exp_r.is_last
            || out_if.ok !== exp_r.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h/%b/%b, got %h/%b/%b",
                     exp_r.response_part, exp_r.is_last, exp_r.ok,
                     out_if.response_part, out_if.is_last, out_if.ok);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    mismatches           = 0;
    items_sent           = 0;
    hold_off             = 1'b0;
    clear_keys();
    in_if.valid          = 1'b0;
    in_if.op             = OpKey1;
    in_if.char_byte      = '0;
    in_if.challenge_word = '0;
    rst_ni               = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_saturation();
    test_random_handshakes(1900);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
